// ===== design/mrb_pkg.sv =====
// ----------------------------------------------------------------------------
// mrb_pkg
// shared widths, codes and types of the modal resonator bank
// ----------------------------------------------------------------------------
package mrb_pkg;

    // input word fields
    localparam int KIND_W        = 2;
    localparam int MODE_INDEX_W  = 7;
    localparam int COEF_W        = 18;
    localparam int STATE_W       = 32;
    localparam int AMOUNT_W      = 32;
    localparam int SAMPLE_W      = 24;

    // packed positions inside s_tdata
    localparam int IDX_LSB       = 0;
    localparam int COS_LSB       = IDX_LSB + MODE_INDEX_W;
    localparam int SIN_LSB       = COS_LSB + COEF_W;
    localparam int ACT_LSB       = SIN_LSB + COEF_W;
    localparam int AMT_LSB       = ACT_LSB + 1;
    localparam int S_FIELDS_W    = AMT_LSB + AMOUNT_W;
    localparam int S_DATA_W      = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_DATA_W      = ((SAMPLE_W + 7) / 8) * 8;

    // kind codes
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXCITE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    // configuration registers
    localparam int MODE_COUNT_W  = 8;
    localparam int OUT_SHIFT_W   = 5;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE_COUNT   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_SHIFT = 1'd1;
    localparam logic [MODE_COUNT_W-1:0] MODE_COUNT_RST  = 8'd32;
    localparam logic [OUT_SHIFT_W-1:0]  OUT_SHIFT_RST   = 5'd8;

    // multiply-accumulate datapath
    localparam int PROD_W        = COEF_W + STATE_W;
    localparam int ACC_W         = PROD_W + 1;

    typedef struct packed {
        logic acc_load;   // capture the registered product into the accumulator
        logic sub;        // result is acc - product instead of acc + product
    } mac_ctrl_t;

endpackage

// ===== design/mrb_mac.sv =====
// ----------------------------------------------------------------------------
// mrb_mac
// shared coefficient by state multiplier with accumulate, shift and saturate
// ----------------------------------------------------------------------------
module mrb_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  mrb_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [mrb_pkg::COEF_W-1:0]   coef,
    input  logic signed [mrb_pkg::STATE_W-1:0]  state_in,
    output logic signed [mrb_pkg::STATE_W-1:0]  result
);
    import mrb_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [ACC_W-1:0]  comb_sum;
    logic signed [ACC_W-1:0]  shifted;
    logic                     ovf;

    assign prod_next = PROD_W'(coef) * PROD_W'(state_in);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctrl.acc_load)
        begin
            acc_reg <= prod_reg;
        end
    end

    // floor shift, then clamp to the state range
    always_comb
    begin
        if (ctrl.sub)
        begin
            comb_sum = ACC_W'(acc_reg) - ACC_W'(prod_reg);
        end
        else
        begin
            comb_sum = ACC_W'(acc_reg) + ACC_W'(prod_reg);
        end
        shifted = comb_sum >>> FRAC_BITS;
        ovf = !((&shifted[ACC_W-1:STATE_W-1]) || !(|shifted[ACC_W-1:STATE_W-1]));
        if (ovf)
        begin
            result = shifted[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                      : {1'b0, {(STATE_W-1){1'b1}}};
        end
        else
        begin
            result = shifted[STATE_W-1:0];
        end
    end

endmodule

// ===== design/modal_resonator_bank_top.sv =====
// ----------------------------------------------------------------------------
// modal_resonator_bank_top
// bank of damped complex resonators, rotated and summed once per tick word
// ----------------------------------------------------------------------------
// The bank takes one word at a time; for a clear, tick or in-range excite word
// it drops s_tready until that word is done; a load word leaves s_tready high.
// A clear word zeroes one state entry per cycle. A tick word rotates every
// active mode below mode_count and skips each inactive one; with mode_count
// zero it rotates none. For each active mode the single shared 18 x 32
// multiplier forms the four products a*re, b*im, b*re, a*im one after another.
// The sample of a tick waits in an output register, so the bank takes the next
// word while it is still unread; a second tick finishes only when that register
// is free. After reset the bank sweeps both mode memories to zero, one entry per
// cycle, before s_tready first rises; configuration writes are taken at any time
// but are meant to be made while the bank is idle.
// ----------------------------------------------------------------------------
module modal_resonator_bank_top #(
    parameter int MODES          = 128,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // input words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // mode_index[6:0], coef_cos[24:7], coef_sin[42:25], active_flag[43],
    // excite_amount[75:44], zero fill[79:76]
    input  logic [mrb_pkg::S_DATA_W-1:0]        s_tdata,
    // kind[1:0]
    input  logic [mrb_pkg::KIND_W-1:0]          s_tuser,

    // output samples
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sample[23:0]
    output logic [mrb_pkg::M_DATA_W-1:0]        m_tdata,
    // clipped[0]
    output logic                                m_tuser,

    // configuration writes
    input  logic                                cfg_we,
    input  logic [mrb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mrb_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import mrb_pkg::*;

    localparam int ADDR_W      = (MODES > 1) ? $clog2(MODES) : 1;
    // wide enough to compare the 7-bit index against MODES itself
    localparam int IW          = ((ADDR_W > MODE_INDEX_W) ? ADDR_W : MODE_INDEX_W) + 1;
    // wide enough to hold both mode_count and MODES
    localparam int CW          = (ADDR_W + 1 > MODE_COUNT_W) ? ADDR_W + 1 : MODE_COUNT_W;
    localparam int SUM_W       = STATE_W + ADDR_W + 1;
    localparam int COEF_WORD_W = 2 * COEF_W + 1;
    localparam int STATE_WORD_W = 2 * STATE_W;

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_CLEAR  = 6'b000100,
        ST_EXCITE = 6'b001000,
        ST_MODE   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    // per-mode sequence of the shared multiplier
    typedef enum logic [4:0] {
        STEP_A_RE  = 5'b00001,
        STEP_B_IM  = 5'b00010,
        STEP_B_RE  = 5'b00100,
        STEP_A_IM  = 5'b01000,
        STEP_WRITE = 5'b10000
    } step_t;

    // control registers
    state_t                   state_reg, state_next;
    step_t                    step_reg, step_next;
    logic [ADDR_W-1:0]        mi_reg, mi_next;      // mode being rotated
    logic [ADDR_W-1:0]        swp_reg, swp_next;    // sweep address
    logic signed [SUM_W-1:0]  sum_reg, sum_next;    // running sum of new imag parts
    logic [MODE_COUNT_W-1:0]  mode_count_reg;
    logic [OUT_SHIFT_W-1:0]   out_shift_reg;
    logic                     out_valid_reg;

    // payload registers
    logic signed [STATE_W-1:0]  nre_reg, nre_next;
    logic [ADDR_W-1:0]          ix_reg;
    logic signed [AMOUNT_W-1:0] amt_reg;
    logic [SAMPLE_W-1:0]        sample_reg;
    logic                       clip_reg;

    // mode memories: {active, cos, sin} and {re, im}
    logic [COEF_WORD_W-1:0]  coef_mem [MODES];
    logic [STATE_WORD_W-1:0] state_mem [MODES];
    logic [COEF_WORD_W-1:0]  coef_rd_reg;
    logic [STATE_WORD_W-1:0] state_rd_reg;

    // memory port controls
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    cw_en;
    logic [ADDR_W-1:0]       cw_addr;
    logic [COEF_WORD_W-1:0]  cw_data;
    logic                    sw_en;
    logic [ADDR_W-1:0]       sw_addr;
    logic [STATE_WORD_W-1:0] sw_data;

    // input word fields
    logic [KIND_W-1:0]          in_kind;
    logic [MODE_INDEX_W-1:0]    in_index;
    logic [COEF_W-1:0]          in_cos;
    logic [COEF_W-1:0]          in_sin;
    logic                       in_active;
    logic [AMOUNT_W-1:0]        in_amount;
    logic [IW-1:0]              idx_wide;
    logic                       in_range;
    logic [ADDR_W-1:0]          in_addr;
    logic                       accept;

    // read-back fields of the current mode
    logic                       rd_active;
    logic signed [COEF_W-1:0]   rd_cos;
    logic signed [COEF_W-1:0]   rd_sin;
    logic signed [STATE_W-1:0]  rd_re;
    logic signed [STATE_W-1:0]  rd_im;

    // misc datapath
    logic [CW-1:0]              eff_cnt;
    logic                       last_mode;
    logic                       advance;
    logic                       swp_last;
    logic                       out_load;
    logic signed [STATE_W:0]    ex_sum;
    logic signed [STATE_W-1:0]  ex_re;
    logic signed [SUM_W-1:0]    out_shifted;
    logic                       out_ovf;
    logic [SAMPLE_W-1:0]        done_sample;

    // shared multiplier
    mac_ctrl_t                  mac_ctrl;
    logic signed [COEF_W-1:0]   mac_coef;
    logic signed [STATE_W-1:0]  mac_state;
    logic signed [STATE_W-1:0]  mac_result;

    // field unpacking
    assign in_kind   = s_tuser;
    assign in_index  = s_tdata[IDX_LSB +: MODE_INDEX_W];
    assign in_cos    = s_tdata[COS_LSB +: COEF_W];
    assign in_sin    = s_tdata[SIN_LSB +: COEF_W];
    assign in_active = s_tdata[ACT_LSB];
    assign in_amount = s_tdata[AMT_LSB +: AMOUNT_W];

    assign idx_wide  = IW'(in_index);
    assign in_range  = idx_wide < IW'(MODES);
    assign in_addr   = idx_wide[ADDR_W-1:0];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    assign rd_active = coef_rd_reg[COEF_WORD_W-1];
    assign rd_cos    = coef_rd_reg[COEF_W +: COEF_W];
    assign rd_sin    = coef_rd_reg[0 +: COEF_W];
    assign rd_re     = state_rd_reg[STATE_W +: STATE_W];
    assign rd_im     = state_rd_reg[0 +: STATE_W];

    // mode_count above MODES is taken as MODES
    assign eff_cnt   = (CW'(mode_count_reg) > CW'(MODES)) ? CW'(MODES) : CW'(mode_count_reg);
    assign last_mode = (CW'(mi_reg) + CW'(1)) == eff_cnt;
    assign swp_last  = (swp_reg == ADDR_W'(MODES - 1));

    // saturating excite add
    assign ex_sum = (STATE_W + 1)'(rd_re) + (STATE_W + 1)'(amt_reg);
    assign ex_re  = (ex_sum[STATE_W] != ex_sum[STATE_W-1])
                  ? (ex_sum[STATE_W] ? {1'b1, {(STATE_W-1){1'b0}}}
                                     : {1'b0, {(STATE_W-1){1'b1}}})
                  : ex_sum[STATE_W-1:0];

    // output scaling: floor shift, then clamp to 24 bits
    assign out_shifted = sum_reg >>> out_shift_reg;
    assign out_ovf = !((&out_shifted[SUM_W-1:SAMPLE_W-1])
                       || !(|out_shifted[SUM_W-1:SAMPLE_W-1]));
    assign done_sample = out_ovf
                       ? (out_shifted[SUM_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                               : {1'b0, {(SAMPLE_W-1){1'b1}}})
                       : out_shifted[SAMPLE_W-1:0];

    // operand selection for the four products of one mode
    always_comb
    begin
        mac_coef  = ((step_reg == STEP_A_RE) || (step_reg == STEP_A_IM)) ? rd_cos : rd_sin;
        mac_state = ((step_reg == STEP_A_RE) || (step_reg == STEP_B_RE)) ? rd_re : rd_im;
        mac_ctrl.acc_load = (step_reg == STEP_B_IM) || (step_reg == STEP_A_IM);
        mac_ctrl.sub      = (step_reg == STEP_B_RE);
    end

    mrb_mac #(
        .FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk      (clk),
        .ctrl     (mac_ctrl),
        .coef     (mac_coef),
        .state_in (mac_state),
        .result   (mac_result)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        mi_next    = mi_reg;
        swp_next   = swp_reg;
        sum_next   = sum_reg;
        nre_next   = nre_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        cw_en      = 1'b0;
        cw_addr    = '0;
        cw_data    = '0;
        sw_en      = 1'b0;
        sw_addr    = '0;
        sw_data    = '0;
        out_load   = 1'b0;
        advance    = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                // zero coefficients, active bits and states after reset
                cw_en   = 1'b1;
                cw_addr = swp_reg;
                sw_en   = 1'b1;
                sw_addr = swp_reg;
                if (swp_last)
                begin
                    swp_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    swp_next = swp_reg + ADDR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (in_kind)
                        KIND_LOAD:
                        begin
                            if (in_range)
                            begin
                                cw_en   = 1'b1;
                                cw_addr = in_addr;
                                cw_data = {in_active, in_cos, in_sin};
                                // an inactive mode always holds a zero state
                                sw_en   = !in_active;
                                sw_addr = in_addr;
                            end
                        end
                        KIND_EXCITE:
                        begin
                            if (in_range)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = in_addr;
                                state_next = ST_EXCITE;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            swp_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            // tick
                            sum_next = '0;
                            mi_next  = '0;
                            if (eff_cnt == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                step_next  = STEP_A_RE;
                                state_next = ST_MODE;
                            end
                        end
                    endcase
                end
            end

            ST_CLEAR:
            begin
                sw_en   = 1'b1;
                sw_addr = swp_reg;
                if (swp_last)
                begin
                    swp_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    swp_next = swp_reg + ADDR_W'(1);
                end
            end

            ST_EXCITE:
            begin
                // excite of an inactive mode is dropped
                sw_en      = rd_active;
                sw_addr    = ix_reg;
                sw_data    = {ex_re, rd_im};
                state_next = ST_IDLE;
            end

            ST_MODE:
            begin
                case (step_reg)
                    STEP_A_RE:
                    begin
                        if (rd_active)
                        begin
                            step_next = STEP_B_IM;
                        end
                        else
                        begin
                            advance = 1'b1;
                        end
                    end
                    STEP_B_IM:
                    begin
                        step_next = STEP_B_RE;
                    end
                    STEP_B_RE:
                    begin
                        nre_next  = mac_result;
                        step_next = STEP_A_IM;
                    end
                    STEP_A_IM:
                    begin
                        step_next = STEP_WRITE;
                    end
                    STEP_WRITE:
                    begin
                        sw_en    = 1'b1;
                        sw_addr  = mi_reg;
                        sw_data  = {nre_reg, mac_result};
                        sum_next = sum_reg + SUM_W'(mac_result);
                        advance  = 1'b1;
                    end
                    default:
                    begin
                        step_next = STEP_A_RE;
                    end
                endcase

                // move on to the next mode in use, reading it ahead
                if (advance)
                begin
                    if (last_mode)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mi_next   = mi_reg + ADDR_W'(1);
                        rd_en     = 1'b1;
                        rd_addr   = mi_reg + ADDR_W'(1);
                        step_next = STEP_A_RE;
                    end
                end
            end

            ST_DONE:
            begin
                // hand the sample over once the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            step_reg      <= STEP_A_RE;
            mi_reg        <= '0;
            swp_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            mi_reg    <= mi_next;
            swp_reg   <= swp_next;
            sum_reg   <= sum_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_count_reg <= MODE_COUNT_RST;
            out_shift_reg  <= OUT_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE_COUNT:   mode_count_reg <= cfg_data[MODE_COUNT_W-1:0];
                CFG_OUTPUT_SHIFT: out_shift_reg  <= cfg_data[OUT_SHIFT_W-1:0];
                default:          ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        nre_reg <= nre_next;
        if (accept)
        begin
            ix_reg  <= in_addr;
            amt_reg <= in_amount;
        end
        if (out_load)
        begin
            sample_reg <= done_sample;
            clip_reg   <= out_ovf;
        end
    end

    // mode memories, registered read
    always_ff @(posedge clk)
    begin
        if (cw_en)
        begin
            coef_mem[cw_addr] <= cw_data;
        end
        if (rd_en)
        begin
            coef_rd_reg <= coef_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sw_en)
        begin
            state_mem[sw_addr] <= sw_data;
        end
        if (rd_en)
        begin
            state_rd_reg <= state_mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(sample_reg);
    assign m_tuser  = clip_reg;

endmodule

// ===== design/mrb_checker.sv =====
// ----------------------------------------------------------------------------
// mrb_checker
// port-level checks of the modal resonator bank, bound to the top level
// ----------------------------------------------------------------------------
module mrb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [mrb_pkg::KIND_W-1:0]    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mrb_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                          m_tuser
);
    import mrb_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // a tick word drops s_tready right after it is taken
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_TICK) |=> !s_tready)
        else $error("ready right after a tick word");

    // a clear sweeps the states before the next word
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_CLEAR) |=> !s_tready)
        else $error("ready right after a clear word");

    // a clipped sample sits at one of the two bounds
    a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            (m_tdata[SAMPLE_W-1:0] == {1'b0, {(SAMPLE_W-1){1'b1}}})
            || (m_tdata[SAMPLE_W-1:0] == {1'b1, {(SAMPLE_W-1){1'b0}}}))
        else $error("clipped flag on a sample inside the range");

endmodule

bind modal_resonator_bank_top mrb_checker u_mrb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
